// ===== hdl/wildcard_glob_matcher_assert.svh =====
// Assertion macros used by the glob matcher datapath.
`ifndef WILDCARD_GLOB_MATCHER_ASSERT_SVH
`define WILDCARD_GLOB_MATCHER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define WGM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wgm assertion failed");
`define WGM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wgm assertion failed");
`else
`define WGM_ASSERT_SAME(label, ante, cons)
`define WGM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/wgm_pkg.sv =====
// Shared constants, action codes and control types of the glob matcher.
package wgm_pkg;

  localparam int MAX_PATTERN_DEF = 64;

  localparam logic [7:0] STAR_BYTE     = 8'd42;
  localparam logic [7:0] QUESTION_BYTE = 8'd63;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_SUBJ   = 2'd2;
  localparam logic [1:0] ACT_END    = 2'd3;

  typedef struct packed {
    logic clear;    // drop pattern, restart subject
    logic append;   // store one pattern byte
    logic start;    // latch subject byte, zero the walk carries
    logic step;     // process pattern position idx
    logic upd;      // step writes the new active bit
    logic fin_sub;  // write active bit at position len
    logic fin_end;  // load result register, restart subject
  } wgm_cmd_t;

  typedef struct packed {
    logic at_end;   // walk index has reached pattern length
    logic out_full; // result register holds a beat not taken this cycle
  } wgm_stat_t;

endpackage

// ===== hdl/wgm_ctrl.sv =====
// Sequencer of the glob matcher: decodes input beats and runs the position walk.
module wgm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [1:0]         in_action,
  input  wgm_pkg::wgm_stat_t stat,
  output wgm_pkg::wgm_cmd_t  cmd
);
  import wgm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUBJ = 2'd1;
  localparam logic [1:0] ST_END  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       acc;

  assign in_tready = (state_r == ST_IDLE);
  assign acc       = in_tvalid & in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_action)
            ACT_CLEAR:  cmd.clear  = 1'b1;
            ACT_APPEND: cmd.append = 1'b1;
            ACT_SUBJ: begin
              cmd.start = 1'b1;
              state_nxt = ST_SUBJ;
            end
            ACT_END: begin
              cmd.start = 1'b1;
              state_nxt = ST_END;
            end
            default: ;
          endcase
        end
      end
      ST_SUBJ: begin
        if (stat.at_end) begin
          cmd.fin_sub = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          cmd.step = 1'b1;
          cmd.upd  = 1'b1;
        end
      end
      ST_END: begin
        if (stat.at_end) begin
          if (!stat.out_full) begin
            cmd.fin_end = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/wgm_datapath.sv =====
// Pattern memory, active-position set, walk carries and result register.
module wgm_datapath #(
  parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  wgm_pkg::wgm_cmd_t  cmd,
  output wgm_pkg::wgm_stat_t stat,
  input  logic [7:0]         in_char,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic               out_matched,
  output logic               out_overflow
);
  import wgm_pkg::*;

  `include "wildcard_glob_matcher_assert.svh"

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_PATTERN);

  logic [7:0]         mem [MAX_PATTERN];
  logic [7:0]         rd_data_r;
  logic [LW-1:0]      len_r;
  logic [LW-1:0]      idx_r, idx_nxt;
  logic [MAX_PATTERN:0] active_r;
  logic               ovf_r;
  logic [7:0]         char_r;
  logic               carry_c_r;
  logic               ncar_r;
  logic               out_valid_r;
  logic               matched_r;
  logic               out_ovf_r;

  logic               star, ques, cc, nx, ncar_n;

  assign star   = (rd_data_r == STAR_BYTE);
  assign ques   = (rd_data_r == QUESTION_BYTE);
  assign cc     = active_r[idx_r] | carry_c_r;
  assign nx     = ncar_r | (cc & star);
  assign ncar_n = (nx & star) | (cc & ~star & (ques | (rd_data_r == char_r)));

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.step) begin
      idx_nxt = idx_r + LW'(1);
    end else if (cmd.fin_sub | cmd.fin_end) begin
      idx_nxt = '0;
    end
  end

  assign stat.at_end   = (idx_r == len_r);
  assign stat.out_full = out_valid_r & ~out_tready;

  assign out_tvalid   = out_valid_r;
  assign out_matched  = matched_r;
  assign out_overflow = out_ovf_r;

  // read address is the next walk index, so rd_data_r holds the byte at idx_r
  always_ff @(posedge clk) begin
    if (cmd.append && (len_r < MAX_LEN)) begin
      mem[len_r[AW-1:0]] <= in_char;
    end
    rd_data_r <= mem[idx_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      char_r <= in_char;
    end
    if (cmd.fin_end) begin
      matched_r <= (active_r[idx_r] | carry_c_r) & ~ovf_r;
      out_ovf_r <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      idx_r       <= '0;
      active_r    <= (MAX_PATTERN + 1)'(1);
      ovf_r       <= 1'b0;
      carry_c_r   <= 1'b0;
      ncar_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.clear) begin
        len_r    <= '0;
        ovf_r    <= 1'b0;
        active_r <= (MAX_PATTERN + 1)'(1);
      end
      if (cmd.append) begin
        if (len_r < MAX_LEN) begin
          len_r <= len_r + LW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
        active_r <= (MAX_PATTERN + 1)'(1);
      end
      if (cmd.start) begin
        carry_c_r <= 1'b0;
        ncar_r    <= 1'b0;
      end
      if (cmd.step) begin
        carry_c_r <= cc & star;
        ncar_r    <= ncar_n;
        if (cmd.upd) begin
          active_r[idx_r] <= nx;
        end
      end
      if (cmd.fin_sub) begin
        active_r[idx_r] <= ncar_r;
      end
      if (cmd.fin_end) begin
        active_r    <= (MAX_PATTERN + 1)'(1);
        out_valid_r <= 1'b1;
      end
    end
  end

  `WGM_ASSERT_SAME(a_step_in_range, cmd.step, idx_r < len_r)
  `WGM_ASSERT_SAME(a_ovf_full, ovf_r, len_r == MAX_LEN)
  `WGM_ASSERT_NEXT(a_end_restart, cmd.fin_end, out_valid_r && (active_r == (MAX_PATTERN + 1)'(1)))
  `WGM_ASSERT_NEXT(a_clear_len, cmd.clear, (len_r == '0) && !ovf_r)

endmodule

// ===== hdl/wildcard_glob_matcher.sv =====
// Top level of the glob matcher: stream ports, sequencer and datapath.
// Matches a subject byte stream against a stored glob pattern ('*' any run,
// '?' one byte). Beats carry an action in in_tuser: clear pattern, append a
// pattern byte, feed a subject byte, or end the subject; only end of subject
// returns a beat (matched, overflow). A subject byte or an end of subject
// walks the pattern memory one position per cycle through its single read
// port; a subject byte updates the active-position set on the way.
// Pattern bytes beyond MAX_PATTERN are dropped and set overflow, which
// forces matched to 0 until the next clear. A result beat waits in an output
// register while new input beats are taken; a later end of subject holds
// in_tready low after its walk until that waiting beat is taken.
module wildcard_glob_matcher #(
  parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_byte
  input  logic [1:0] in_tuser,   // [1:0] action
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] matched, [1] overflow, [7:2] zero
);
  import wgm_pkg::*;

  wgm_cmd_t  cmd;
  wgm_stat_t stat;
  logic      matched;
  logic      overflow;

  wgm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_action (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  wgm_datapath #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_char      (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_matched  (matched),
    .out_overflow (overflow)
  );

  assign out_tdata = {6'b0, overflow, matched};

endmodule

// ===== tb/sv/tb_wildcard_glob_matcher.sv =====
// Testbench for the glob matcher: stream driver, result sink, active-set predictor and checker.
`timescale 1ns / 100ps

module tb_wildcard_glob_matcher;
  import wgm_pkg::*;

  localparam int MAX_PAT = wgm_pkg::MAX_PATTERN_DEF;
  localparam int NUM_ITEMS = 1650;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_byte;
    logic       drain_first;
  } glob_beat_t;

  typedef struct packed {
    logic overflow;
    logic matched;
  } glob_verdict_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic [1:0] in_tuser = ACT_CLEAR;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;

  glob_beat_t    beat_queue[$];
  glob_verdict_t verdicts[$];
  logic [7:0]    gen_pat[$];
  logic          drain_next = 1'b0;
  int            n_items = 0;
  int            err_count = 0;
  int            results_owed = 0;
  int            tx_gap = 0;
  int            tx_burst = 0;
  int            rx_hold = 0;
  int            rx_burst = 0;
  int            rx_taken = 0;

  logic [7:0]       pat_mem [MAX_PAT];
  int               pat_len;
  logic [MAX_PAT:0] live;
  logic             ovf;

  wildcard_glob_matcher uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // predictor: active pattern positions
  function automatic void spread_stars();
    for (int i = 0; i < pat_len; i++)
      if (live[i] && pat_mem[i] == STAR_BYTE) live[i + 1] = 1'b1;
  endfunction

  function automatic void glob_step(logic [1:0] act, logic [7:0] ch);
    logic [MAX_PAT:0] nxt;
    glob_verdict_t    v;
    nxt = '0;
    case (act)
      ACT_CLEAR: begin
        pat_len = 0;
        ovf = 1'b0;
      end
      ACT_APPEND: begin
        if (pat_len < MAX_PAT) begin
          pat_mem[pat_len] = ch;
          pat_len++;
        end else begin
          ovf = 1'b1;
        end
      end
      ACT_SUBJ: begin
        spread_stars();
        for (int i = 0; i < pat_len; i++) begin
          if (live[i]) begin
            if (pat_mem[i] == STAR_BYTE) nxt[i] = 1'b1;
            else if (pat_mem[i] == QUESTION_BYTE || pat_mem[i] == ch) nxt[i + 1] = 1'b1;
          end
        end
        live = nxt;
        spread_stars();
      end
      default: begin
        spread_stars();
        v.matched = live[pat_len] && !ovf;
        v.overflow = ovf;
        verdicts.insert(verdicts.size(), v);
      end
    endcase
    if (act != ACT_SUBJ) begin
      live = '0;
      live[0] = 1'b1;
    end
  endfunction

  // stimulus helpers
  function automatic void push_beat(logic [1:0] act, logic [7:0] ch);
    glob_beat_t b;
    b.action = act;
    b.char_byte = ch;
    b.drain_first = drain_next;
    drain_next = 1'b0;
    beat_queue.insert(beat_queue.size(), b);
    n_items++;
    if (act == ACT_CLEAR) gen_pat.delete();
    else if (act == ACT_APPEND && gen_pat.size() < MAX_PAT) gen_pat.insert(gen_pat.size(), ch);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 15);
    if (r < 5) return 8'h61;
    if (r < 8) return 8'h62;
    if (r == 8) return 8'h00;
    if (r == 9) return STAR_BYTE;
    if (r == 10) return QUESTION_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pat_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return STAR_BYTE;
    if (r == 2) return QUESTION_BYTE;
    return pick_byte();
  endfunction

  function automatic void add_subject();
    logic [7:0] subj[$];
    int         k;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(0, 10)) subj.insert(subj.size(), pick_byte());
    end else begin
      foreach (gen_pat[i]) begin
        if (gen_pat[i] == STAR_BYTE)
          repeat ($urandom_range(0, 3)) subj.insert(subj.size(), pick_byte());
        else if (gen_pat[i] == QUESTION_BYTE)
          subj.insert(subj.size(), 8'($urandom_range(0, 255)));
        else
          subj.insert(subj.size(), gen_pat[i]);
      end
      if ($urandom_range(0, 3) == 0) begin
        k = $urandom_range(0, 2);
        if (k == 0 && subj.size() > 0)
          void'(subj.pop_back());
        else if (k == 1)
          subj.insert($urandom_range(0, subj.size()), pick_byte());
        else if (subj.size() > 0)
          subj[$urandom_range(0, subj.size() - 1)] = pick_byte();
      end
    end
    foreach (subj[i]) push_beat(ACT_SUBJ, subj[i]);
    push_beat(ACT_END, 8'($urandom_range(0, 255)));
  endfunction

  // driver
  always @(posedge clk) begin : drive_proc
    glob_beat_t beat;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= ACT_CLEAR;
      tx_gap <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_tvalid <= 1'b0;
      end else if (beat_queue.size() == 0 ||
                   (beat_queue[0].drain_first && (in_tvalid || results_owed != 0))) begin
        in_tvalid <= 1'b0;
      end else begin
        beat = beat_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= beat.char_byte;
        in_tuser <= beat.action;
        tx_gap <= draw_wait(tx_burst);
      end
    end
  end

  // result sink, with two long hold-offs to back up the block
  always @(posedge clk) begin : sink_proc
    int hold;
    if (!rst_n) begin
      out_tready <= 1'b1;
      rx_hold <= 0;
      rx_taken <= 0;
    end else begin
      hold = rx_hold;
      if (out_tvalid && out_tready) begin
        if (rx_taken == 30 || rx_taken == 120) hold = 300;
        else hold = draw_wait(rx_burst);
        rx_taken <= rx_taken + 1;
      end else if (hold > 0) begin
        hold--;
      end
      rx_hold <= hold;
      out_tready <= (hold == 0);
    end
  end

  // checker: results first, then the input beat of this edge
  always @(posedge clk) begin : check_proc
    glob_verdict_t want;
    if (!rst_n) begin
      pat_len = 0;
      ovf = 1'b0;
      live = '0;
      live[0] = 1'b1;
      verdicts.delete();
      results_owed <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (verdicts.size() == 0) begin
          report_mismatch($sformatf("result beat 0x%02h with no end of subject pending",
                                    out_tdata));
        end else begin
          want = verdicts.pop_front();
          if (out_tdata[0] !== want.matched)
            report_mismatch($sformatf("matched got %b want %b", out_tdata[0], want.matched));
          if (out_tdata[1] !== want.overflow)
            report_mismatch($sformatf("overflow got %b want %b", out_tdata[1], want.overflow));
          if (out_tdata[7:2] !== 6'd0)
            report_mismatch($sformatf("padding bits got 0x%02h", out_tdata[7:2]));
        end
      end
      if (in_tvalid && in_tready) glob_step(in_tuser, in_tdata);
      results_owed <= verdicts.size();
    end
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stim_proc
    int  r;
    bit  mid_drain_done;
    mid_drain_done = 1'b0;

    // directed
    push_beat(ACT_END, 8'h00);
    push_beat(ACT_SUBJ, 8'h61);
    push_beat(ACT_END, 8'h00);
    push_beat(ACT_APPEND, STAR_BYTE);
    push_beat(ACT_END, 8'hFF);
    push_beat(ACT_SUBJ, 8'h00);
    push_beat(ACT_SUBJ, 8'hFF);
    push_beat(ACT_END, 8'h00);
    push_beat(ACT_CLEAR, 8'h00);
    push_beat(ACT_APPEND, QUESTION_BYTE);
    push_beat(ACT_APPEND, 8'h00);
    push_beat(ACT_SUBJ, 8'hFF);
    push_beat(ACT_SUBJ, 8'h00);
    push_beat(ACT_END, 8'h00);
    push_beat(ACT_SUBJ, 8'h55);
    push_beat(ACT_APPEND, STAR_BYTE);
    push_beat(ACT_END, 8'h00);
    push_beat(ACT_CLEAR, 8'hFF);
    push_beat(ACT_END, 8'hAA);
    drain_next = 1'b1;

    // random
    while (n_items < NUM_ITEMS) begin
      if (!mid_drain_done && n_items >= 900) begin
        drain_next = 1'b1;
        mid_drain_done = 1'b1;
      end
      if ($urandom_range(0, 19) < 17) begin
        r = $urandom_range(0, 24);
        if (r == 0) begin
          push_beat(ACT_CLEAR, 8'($urandom_range(0, 255)));
          repeat ($urandom_range(MAX_PAT + 1, MAX_PAT + 6)) push_beat(ACT_APPEND, pat_byte());
        end else if (r == 1) begin
          push_beat(ACT_CLEAR, 8'($urandom_range(0, 255)));
          repeat (MAX_PAT) push_beat(ACT_APPEND, pat_byte());
        end else begin
          if ($urandom_range(0, 4) != 0) push_beat(ACT_CLEAR, 8'($urandom_range(0, 255)));
          repeat ($urandom_range(0, 8)) push_beat(ACT_APPEND, pat_byte());
        end
        repeat ($urandom_range(1, 3)) add_subject();
      end else begin
        repeat ($urandom_range(1, 6))
          push_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // sampled away from the rising edge so every update of that edge has landed
    do @(negedge clk); while (beat_queue.size() != 0 || in_tvalid || results_owed != 0);
    repeat (150) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/wgm_pkg.sv
hdl/wgm_ctrl.sv
hdl/wgm_datapath.sv
hdl/wildcard_glob_matcher.sv
tb/sv/tb_wildcard_glob_matcher.sv
